### src/mpfd_pkg.sv
// Package: shared constants, types and the font table for the framebuffer draw engine.
package mpfd_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_PIXEL  = 3'd1;
    localparam logic [2:0] CMD_GLYPH  = 3'd2;
    localparam logic [2:0] CMD_RECT   = 3'd3;
    localparam logic [2:0] CMD_GRAY   = 3'd4;
    localparam logic [2:0] CMD_BORDER = 3'd5;
    localparam logic [2:0] CMD_READ   = 3'd6;

    localparam logic [7:0] CHAR_FIRST   = 8'h41; // 'A'
    localparam logic [7:0] CHAR_LAST    = 8'h7A; // 'z'
    localparam logic [7:0] CHAR_LOWER   = 8'h61; // 'a'
    localparam logic [5:0] LOWER_OFFSET = 6'd26;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] w;
        logic [7:0] h;
        logic       pixel_on;
        logic [5:0] glyph_sel;
        logic       glyph_ok;
        logic [1:0] gray_mode;   // 0 off, 1 checker, 2 on
        logic       border_solid;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } mpfd_cmd_t;

    localparam logic [1:0] GRAY_OFF   = 2'd0;
    localparam logic [1:0] GRAY_CHECK = 2'd1;
    localparam logic [1:0] GRAY_ON    = 2'd2;

    function automatic logic [39:0] glyph_bits(input logic [5:0] sel);
        logic [39:0] g;
        begin
            unique case (sel)
                6'd0:  g = 40'h7E1111117E;
                6'd1:  g = 40'h7F49494936;
                6'd2:  g = 40'h3E41414122;
                6'd3:  g = 40'h7F4141221C;
                6'd4:  g = 40'h7F49494941;
                6'd5:  g = 40'h7F09090901;
                6'd6:  g = 40'h3E4149497A;
                6'd7:  g = 40'h7F0808087F;
                6'd8:  g = 40'h00417F4100;
                6'd9:  g = 40'h2040413F01;
                6'd10: g = 40'h7F08142241;
                6'd11: g = 40'h7F40404040;
                6'd12: g = 40'h7F020C027F;
                6'd13: g = 40'h7F0408107F;
                6'd14: g = 40'h3E4141413E;
                6'd15: g = 40'h7F09090906;
                6'd16: g = 40'h3E4151215E;
                6'd17: g = 40'h7F09192946;
                6'd18: g = 40'h4649494931;
                6'd19: g = 40'h01017F0101;
                6'd20: g = 40'h3F4040403F;
                6'd21: g = 40'h1F2040201F;
                6'd22: g = 40'h3F4038403F;
                6'd23: g = 40'h6314081463;
                6'd24: g = 40'h0708700807;
                6'd25: g = 40'h6151494543;
                6'd26: g = 40'h2054545478;
                6'd27: g = 40'h7F48444438;
                6'd28: g = 40'h3844444428;
                6'd29: g = 40'h384444487F;
                6'd30: g = 40'h3854545418;
                6'd31: g = 40'h087E090102;
                6'd32: g = 40'h081454543C;
                6'd33: g = 40'h7F08040478;
                6'd34: g = 40'h00447D4000;
                6'd35: g = 40'h2040443D00;
                6'd36: g = 40'h7F10284400;
                6'd37: g = 40'h00417F4000;
                6'd38: g = 40'h7C04180478;
                6'd39: g = 40'h7C08040478;
                6'd40: g = 40'h3844444438;
                6'd41: g = 40'h7C14141408;
                6'd42: g = 40'h081414187C;
                6'd43: g = 40'h7C08040408;
                6'd44: g = 40'h4854545420;
                6'd45: g = 40'h043F444020;
                6'd46: g = 40'h3C4040207C;
                6'd47: g = 40'h1C2040201C;
                6'd48: g = 40'h3C4030403C;
                6'd49: g = 40'h4428102844;
                6'd50: g = 40'h0C5050503C;
                6'd51: g = 40'h4464544C44;
                default: g = 40'h0;
            endcase
            glyph_bits = g;
        end
    endfunction

endpackage

### src/mpfd_if.sv
// Interfaces: valid/ready channels for commands and read results.
interface mpfd_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       pixel_on;
    logic [7:0] char_code;
    logic [7:0] shade_level;
    logic       border_solid;
    logic [2:0] read_page;
    logic [6:0] read_column;
    modport source (output valid, command, x_pos, y_pos, rect_width, rect_height, pixel_on,
                    char_code, shade_level, border_solid, read_page, read_column,
                    input ready);
    modport sink (input valid, command, x_pos, y_pos, rect_width, rect_height, pixel_on,
                  char_code, shade_level, border_solid, read_page, read_column,
                  output ready);
endinterface

interface mpfd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

### src/mpfd_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
module mpfd_front
(
    input  logic                clk,
    input  logic                rst_n,
    mpfd_cmd_if.sink            cmd,
    output mpfd_pkg::mpfd_cmd_t q_data,
    output logic                q_valid,
    input  logic                q_pop
);
    localparam int DEPTH = 2;

    mpfd_pkg::mpfd_cmd_t entry_reg [DEPTH];
    logic [0:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    mpfd_pkg::mpfd_cmd_t cls;
    logic push;

    always_comb
    begin
        cls.command      = cmd.command;
        cls.x_pos        = cmd.x_pos;
        cls.y_pos        = cmd.y_pos;
        cls.w            = cmd.rect_width;
        cls.h            = cmd.rect_height;
        cls.pixel_on     = cmd.pixel_on;
        cls.border_solid = cmd.border_solid;
        cls.read_page    = cmd.read_page;
        cls.read_column  = cmd.read_column;
        cls.glyph_ok     = (cmd.char_code >= mpfd_pkg::CHAR_FIRST) &&
                           (cmd.char_code <= mpfd_pkg::CHAR_LAST);
        if (cmd.char_code >= mpfd_pkg::CHAR_LOWER)
            cls.glyph_sel = 6'(cmd.char_code - mpfd_pkg::CHAR_LOWER) + mpfd_pkg::LOWER_OFFSET;
        else
            cls.glyph_sel = 6'(cmd.char_code - mpfd_pkg::CHAR_FIRST);
        if (cmd.shade_level >= 8'd1 && cmd.shade_level <= 8'd3)
            cls.gray_mode = mpfd_pkg::GRAY_CHECK;
        else if (cmd.shade_level == 8'd4)
            cls.gray_mode = mpfd_pkg::GRAY_ON;
        else
            cls.gray_mode = mpfd_pkg::GRAY_OFF;
    end

    assign cmd.ready = (count_reg != 2'(DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cls;
    end
endmodule

### src/mpfd_back.sv
// Back end: walks each command over the frame store by read-modify-write of bytes.
module mpfd_back
#(
    parameter int SCREEN_WIDTH  = mpfd_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpfd_pkg::SCREEN_HEIGHT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mpfd_pkg::mpfd_cmd_t q_data,
    input  logic                q_valid,
    output logic                q_pop,
    mpfd_res_if.source          res
);
    localparam int PAGES      = (SCREEN_HEIGHT + 7) / 8;
    localparam int BYTES      = PAGES * SCREEN_WIDTH;
    localparam int AW         = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int BORDER_LEN = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_RDW   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [7:0] mem [BYTES];
    logic [7:0] rdata_reg;

    logic [2:0] state_reg, state_next;
    mpfd_pkg::mpfd_cmd_t c_reg, c_next;
    logic [8:0] i_reg, i_next, j_reg, j_next;    // pixel walk counters
    logic [AW:0] clr_reg, clr_next;
    logic [7:0] out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    logic       init_reg, init_next;             // sweep after reset, no result

    // current pixel, its value and byte address
    logic [7:0] px, py;
    logic       pv, pin;
    logic [8:0] i_lim, j_lim;
    logic [AW-1:0] addr;
    logic       mem_we;
    logic [7:0] wdata;
    logic       last;
    logic [39:0] gbits;
    logic       bstep;

    always_comb
    begin
        gbits = mpfd_pkg::glyph_bits(c_reg.glyph_sel);
        bstep = c_reg.border_solid;
        px = c_reg.x_pos + i_reg[7:0];
        py = c_reg.y_pos + j_reg[7:0];
        pv = c_reg.pixel_on;
        i_lim = {1'b0, c_reg.w};
        j_lim = {1'b0, c_reg.h};
        unique case (c_reg.command)
            mpfd_pkg::CMD_PIXEL:
            begin
                i_lim = 9'd1;
                j_lim = 9'd1;
            end
            mpfd_pkg::CMD_GLYPH:
            begin
                i_lim = 9'd5;
                j_lim = 9'd8;
                pv = gbits[6'(8 * (4 - i_reg[2:0])) + 6'(j_reg[2:0])];
            end
            mpfd_pkg::CMD_GRAY:
            begin
                if (c_reg.gray_mode == mpfd_pkg::GRAY_CHECK)
                    pv = ~(i_reg[0] ^ j_reg[0]);
                else
                    pv = (c_reg.gray_mode == mpfd_pkg::GRAY_ON);
            end
            mpfd_pkg::CMD_BORDER:
            begin
                // i walks the position, j picks the edge: top, bottom, left, right
                i_lim = 9'(BORDER_LEN);
                j_lim = 9'd4;
                pv = 1'b1;
                unique case (j_reg[1:0])
                    2'd0: begin px = i_reg[7:0]; py = 8'd0; end
                    2'd1: begin px = i_reg[7:0]; py = 8'(SCREEN_HEIGHT - 1); end
                    2'd2: begin px = 8'd0; py = i_reg[7:0]; end
                    default: begin px = 8'(SCREEN_WIDTH - 1); py = i_reg[7:0]; end
                endcase
            end
            default: ;
        endcase
        pin = (32'(px) < SCREEN_WIDTH) && (32'(py) < SCREEN_HEIGHT);
        if (c_reg.command == mpfd_pkg::CMD_BORDER)
            pin = pin && (bstep || !i_reg[0]) &&
                  (j_reg[1] ? (32'(i_reg) < SCREEN_HEIGHT) : (32'(i_reg) < SCREEN_WIDTH));
        last = (i_reg + 9'd1 >= i_lim) && (j_reg + 9'd1 >= j_lim);
    end

    always_comb
    begin
        state_next     = state_reg;
        c_next         = c_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        clr_next       = clr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        init_next      = init_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        addr           = AW'((32'(py) >> 3) * SCREEN_WIDTH + 32'(px));
        wdata          = pv ? (rdata_reg | (8'd1 << py[2:0]))
                            : (rdata_reg & ~(8'd1 << py[2:0]));
        if (res.valid && res.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop  = 1'b1;
                    c_next = q_data;
                    i_next = '0;
                    j_next = '0;
                    clr_next = '0;
                    out_next = 8'd0;
                    unique case (q_data.command)
                        mpfd_pkg::CMD_CLEAR: state_next = ST_CLEAR;
                        mpfd_pkg::CMD_READ:  state_next = ST_READ;
                        mpfd_pkg::CMD_PIXEL, mpfd_pkg::CMD_BORDER: state_next = ST_RD;
                        mpfd_pkg::CMD_GLYPH:
                            state_next = q_data.glyph_ok ? ST_RD : ST_OUT;
                        mpfd_pkg::CMD_RECT, mpfd_pkg::CMD_GRAY:
                            state_next = (q_data.w == 8'd0 || q_data.h == 8'd0) ? ST_OUT : ST_RD;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                addr   = clr_reg[AW-1:0];
                wdata  = 8'd0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == BYTES - 1)
                begin
                    // the clearing pass after reset raises no result
                    state_next = init_reg ? ST_IDLE : ST_OUT;
                    init_next  = 1'b0;
                end
            end
            ST_RD:
            begin
                state_next = pin ? ST_WAIT : ST_WR;
            end
            ST_WAIT:
                state_next = ST_WR;
            ST_WR:
            begin
                mem_we = pin;
                if (last)
                    state_next = ST_OUT;
                else
                begin
                    state_next = ST_RD;
                    if (j_reg + 9'd1 >= j_lim)
                    begin
                        j_next = '0;
                        i_next = i_reg + 9'd1;
                    end
                    else
                        j_next = j_reg + 9'd1;
                end
            end
            ST_READ:
            begin
                addr = AW'(32'(c_reg.read_page) * SCREEN_WIDTH + 32'(c_reg.read_column));
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                if (32'(c_reg.read_page) < PAGES && 32'(c_reg.read_column) < SCREEN_WIDTH)
                    out_next = rdata_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // single-port frame store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            i_reg         <= '0;
            j_reg         <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            init_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            init_reg      <= init_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.read_data = out_reg;
endmodule

### src/mono_page_framebuffer_draw.sv
// Top level: monochrome page framebuffer drawing engine.
//
//  channel | dir | payload
//  cmd     | in  | command, x_pos, y_pos, rect_width, rect_height, pixel_on,
//          |     | char_code, shade_level, border_solid, read_page, read_column
//  res     | out | read_data (one transaction per command)
//
// Flow: the idle state takes a command from the queue and the out state raises its
// result; between them each touched pixel passes the read, wait and write states of
// read-modify-write on the single-port frame store (read and write only for pixels
// off screen). Clear writes every byte; read fetches one byte. After reset the store
// is swept clear, byte by byte, while commands queue but are not run.
// A two-entry queue decouples the front end; the next command starts the cycle
// after the pending result transaction is taken.
module mono_page_framebuffer_draw
#(
    parameter int SCREEN_WIDTH  = mpfd_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpfd_pkg::SCREEN_HEIGHT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    mpfd_cmd_if.sink  cmd,
    mpfd_res_if.source res
);
    mpfd_pkg::mpfd_cmd_t q_data;
    logic q_valid, q_pop;

    mpfd_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    mpfd_back
    #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .res     (res)
    );

    // a popped command needs a valid queue entry
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");
    // no pop while a result is still pending
    a_pop_out: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !res.valid)
        else $error("command started with result pending");
    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid)
        else $error("result dropped under stall");
endmodule
